[hdl/ewa_pkg.sv]
// Shared types and constants for the EMA filter with windowed average.
`timescale 1ns / 1ps

package ewa_pkg;

    localparam int TIME_W     = 32;
    localparam int INTERVAL_W = 16;
    localparam int WEIGHT_W   = 16;
    localparam int MUL_CNT_W  = 4;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    localparam logic [INTERVAL_W-1:0] SAMPLE_IVL_RST  = 16'd20;
    localparam logic [INTERVAL_W-1:0] DISPLAY_IVL_RST = 16'd250;
    localparam logic [WEIGHT_W-1:0]   EMA_WEIGHT_RST  = 16'd9830;

    typedef enum logic [1:0] {
        REG_SAMPLE_IVL  = 2'd0,
        REG_DISPLAY_IVL = 2'd1,
        REG_EMA_WEIGHT  = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_LOAD,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

[hdl/ema_filter_with_windowed_average_top.sv]
// EMA temperature filter with a windowed average, serial multiply and divide.
//
// Input channel (in_valid / in_stall): one beat carries now_ms and a signed
// sample in 1/64 degree units. Output channel (out_valid / out_stall): one
// beat per input beat with the moving average, the latest window average and
// two flags telling whether this beat updated either of them.
// The block works on one beat at a time. After a beat is taken it runs a
// bit-serial shift-add multiplier (one weight bit a cycle) when the sample
// interval has elapsed, and a restoring divider (one quotient bit a cycle)
// when a window average is due and the window is not empty. The result
// enters the output register as the block returns to idle for the next beat.
// The output is a register: a waiting result does not hold up the next beat;
// if the receiver still stalls when the next result is ready the block waits.
// Reset clears the filter, the window and both time stamps, and loads the
// interval and weight registers with 20 ms, 250 ms and 9830.
// Configuration is written over the APB port. The user must write it only
// while the block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps

module ema_filter_with_windowed_average_top
    import ewa_pkg::*;
#(
    parameter int SAMPLE_BITS = 18,
    parameter int MAX_COUNT   = 255
)(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [TIME_W-1:0]             now_ms,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] filtered_temp,
    output logic signed [SAMPLE_BITS-1:0] display_temp,
    output logic                          sample_taken,
    output logic                          display_updated,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_W-1:0]             paddr,
    input  logic [DATA_W-1:0]             pwdata,
    output logic [DATA_W-1:0]             prdata,
    output logic                          pready
);

    localparam int SB        = SAMPLE_BITS;
    localparam int CW        = $clog2(MAX_COUNT + 1);
    localparam int SUMW      = SB + CW;
    localparam int HW        = SB + 2;
    localparam int DIV_CNT_W = $clog2(SUMW);

    state_t state_reg, state_next;

    logic [INTERVAL_W-1:0] sample_ivl_reg, display_ivl_reg;
    logic [WEIGHT_W-1:0]   weight_reg;

    logic [TIME_W-1:0]   last_sample_time_reg, last_sample_time_next;
    logic [TIME_W-1:0]   last_display_time_reg, last_display_time_next;
    logic [SB-1:0]       filter_value_reg, filter_value_next;
    logic                filter_seeded_reg, filter_seeded_next;
    logic [SUMW-1:0]     window_sum_reg, window_sum_next;
    logic [CW-1:0]       window_count_reg, window_count_next;
    logic [SB-1:0]       display_value_reg, display_value_next;
    logic                sample_due_reg, sample_due_next;
    logic                disp_due_reg, disp_due_next;
    logic                shown_reg, shown_next;
    logic                out_valid_reg, out_valid_next;
    logic [MUL_CNT_W-1:0] mul_cnt_reg, mul_cnt_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    // datapath, no reset
    logic [SB-1:0]       f_base_reg, f_base_next;
    logic [SB:0]         diff_reg, diff_next;
    logic [HW-1:0]       prod_hi_reg, prod_hi_next;
    logic [WEIGHT_W-1:0] prod_lo_reg, prod_lo_next;
    logic [SUMW-1:0]     dvd_reg, dvd_next;
    logic [CW-1:0]       rem_reg, rem_next;
    logic [CW-1:0]       den_reg, den_next;
    logic                div_neg_reg, div_neg_next;
    logic [SB-1:0]       filtered_temp_reg, filtered_temp_next;
    logic [SB-1:0]       display_temp_reg, display_temp_next;
    logic                sample_taken_reg, sample_taken_next;
    logic                display_updated_reg, display_updated_next;

    logic                  accept;
    logic                  out_load;
    logic                  cfg_write;
    reg_idx_t              cfg_idx;
    logic [TIME_W-1:0]     elapsed_s, elapsed_d;
    logic                  s_due, d_due;
    logic [SB-1:0]         f0;
    logic [HW-1:0]         hi_sum;
    logic [SB-1:0]         f_new;
    logic [CW:0]           rem_shift, rem_trial;
    logic                  q_bit;
    logic [SUMW-1:0]       dvd_step;

    // ---------------------------------------------------------------- config

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_idx   = reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        case (cfg_idx)
            REG_SAMPLE_IVL:  prdata = {{(DATA_W-INTERVAL_W){1'b0}}, sample_ivl_reg};
            REG_DISPLAY_IVL: prdata = {{(DATA_W-INTERVAL_W){1'b0}}, display_ivl_reg};
            REG_EMA_WEIGHT:  prdata = {{(DATA_W-WEIGHT_W){1'b0}}, weight_reg};
            default:         prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- control

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid & ~in_stall;
    assign out_load = (state_reg == ST_DONE) & (~out_valid_reg | ~out_stall);

    assign elapsed_s = now_ms - last_sample_time_reg;
    assign elapsed_d = now_ms - last_display_time_reg;
    assign s_due = elapsed_s >= {{(TIME_W-INTERVAL_W){1'b0}}, sample_ivl_reg};
    assign d_due = elapsed_d >= {{(TIME_W-INTERVAL_W){1'b0}}, display_ivl_reg};

    // first sample seeds the filter
    assign f0 = filter_seeded_reg ? filter_value_reg : sample;

    // shift-add step: weight bits are taken from the bottom of the low half
    assign hi_sum = prod_lo_reg[0] ? (prod_hi_reg + {diff_reg[SB], diff_reg}) : prod_hi_reg;
    assign f_new  = f_base_reg + prod_hi_reg[SB-1:0];

    // restoring divide step
    assign rem_shift = {rem_reg, dvd_reg[SUMW-1]};
    assign rem_trial = rem_shift - {1'b0, den_reg};
    assign q_bit     = rem_shift >= {1'b0, den_reg};
    assign dvd_step  = {dvd_reg[SUMW-2:0], q_bit};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = s_due ? ST_MUL : ST_ACC;
            end
            ST_MUL:
            begin
                if (mul_cnt_reg == {MUL_CNT_W{1'b1}})
                    state_next = ST_ACC;
            end
            ST_ACC:
                state_next = ST_LOAD;
            ST_LOAD:
            begin
                if (disp_due_reg && window_count_reg != '0)
                    state_next = ST_DIV;
                else
                    state_next = ST_DONE;
            end
            ST_DIV:
            begin
                if (div_cnt_reg == '0)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        last_sample_time_next  = last_sample_time_reg;
        last_display_time_next = last_display_time_reg;
        filter_value_next      = filter_value_reg;
        filter_seeded_next     = filter_seeded_reg;
        window_sum_next        = window_sum_reg;
        window_count_next      = window_count_reg;
        display_value_next     = display_value_reg;
        sample_due_next        = sample_due_reg;
        disp_due_next          = disp_due_reg;
        shown_next             = shown_reg;
        mul_cnt_next           = mul_cnt_reg;
        div_cnt_next           = div_cnt_reg;
        f_base_next            = f_base_reg;
        diff_next              = diff_reg;
        prod_hi_next           = prod_hi_reg;
        prod_lo_next           = prod_lo_reg;
        dvd_next               = dvd_reg;
        rem_next               = rem_reg;
        den_next               = den_reg;
        div_neg_next           = div_neg_reg;
        filtered_temp_next     = filtered_temp_reg;
        display_temp_next      = display_temp_reg;
        sample_taken_next      = sample_taken_reg;
        display_updated_next   = display_updated_reg;
        out_valid_next         = out_valid_reg & out_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    sample_due_next = s_due;
                    disp_due_next   = d_due;
                    shown_next      = 1'b0;
                    f_base_next     = f0;
                    diff_next       = {sample[SB-1], sample} - {f0[SB-1], f0};
                    prod_hi_next    = '0;
                    prod_lo_next    = weight_reg;
                    mul_cnt_next    = '0;
                    if (s_due)
                    begin
                        last_sample_time_next = now_ms;
                        filter_seeded_next    = 1'b1;
                    end
                    if (d_due)
                        last_display_time_next = now_ms;
                end
            end
            ST_MUL:
            begin
                // arithmetic shift right keeps the high half a floored quotient
                prod_hi_next = {hi_sum[HW-1], hi_sum[HW-1:1]};
                prod_lo_next = {hi_sum[0], prod_lo_reg[WEIGHT_W-1:1]};
                mul_cnt_next = mul_cnt_reg + 1'b1;
            end
            ST_ACC:
            begin
                if (sample_due_reg)
                begin
                    filter_value_next = f_new;
                    if (window_count_reg < CW'(MAX_COUNT))
                    begin
                        window_sum_next   = window_sum_reg
                                          + {{(SUMW-SB){f_new[SB-1]}}, f_new};
                        window_count_next = window_count_reg + 1'b1;
                    end
                end
            end
            ST_LOAD:
            begin
                if (disp_due_reg && window_count_reg != '0)
                begin
                    div_neg_next      = window_sum_reg[SUMW-1];
                    dvd_next          = window_sum_reg[SUMW-1] ? -window_sum_reg
                                                               : window_sum_reg;
                    den_next          = window_count_reg;
                    rem_next          = '0;
                    div_cnt_next      = DIV_CNT_W'(SUMW - 1);
                    window_sum_next   = '0;
                    window_count_next = '0;
                end
            end
            ST_DIV:
            begin
                dvd_next     = dvd_step;
                rem_next     = q_bit ? rem_trial[CW-1:0] : rem_shift[CW-1:0];
                div_cnt_next = div_cnt_reg - 1'b1;
                if (div_cnt_reg == '0)
                begin
                    // sign applied to the magnitude quotient: truncation toward zero
                    display_value_next = div_neg_reg ? -dvd_step[SB-1:0] : dvd_step[SB-1:0];
                    shown_next         = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    filtered_temp_next   = filter_value_reg;
                    display_temp_next    = display_value_reg;
                    sample_taken_next    = sample_due_reg;
                    display_updated_next = shown_reg;
                    out_valid_next       = 1'b1;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg & out_stall;
            end
        endcase
    end

    // ---------------------------------------------------------------- registers

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg             <= ST_IDLE;
            sample_ivl_reg        <= SAMPLE_IVL_RST;
            display_ivl_reg       <= DISPLAY_IVL_RST;
            weight_reg            <= EMA_WEIGHT_RST;
            last_sample_time_reg  <= '0;
            last_display_time_reg <= '0;
            filter_value_reg      <= '0;
            filter_seeded_reg     <= 1'b0;
            window_sum_reg        <= '0;
            window_count_reg      <= '0;
            display_value_reg     <= '0;
            sample_due_reg        <= 1'b0;
            disp_due_reg          <= 1'b0;
            shown_reg             <= 1'b0;
            out_valid_reg         <= 1'b0;
            mul_cnt_reg           <= '0;
            div_cnt_reg           <= '0;
        end
        else
        begin
            state_reg             <= state_next;
            last_sample_time_reg  <= last_sample_time_next;
            last_display_time_reg <= last_display_time_next;
            filter_value_reg      <= filter_value_next;
            filter_seeded_reg     <= filter_seeded_next;
            window_sum_reg        <= window_sum_next;
            window_count_reg      <= window_count_next;
            display_value_reg     <= display_value_next;
            sample_due_reg        <= sample_due_next;
            disp_due_reg          <= disp_due_next;
            shown_reg             <= shown_next;
            out_valid_reg         <= out_valid_next;
            mul_cnt_reg           <= mul_cnt_next;
            div_cnt_reg           <= div_cnt_next;
            if (cfg_write)
            begin
                case (cfg_idx)
                    REG_SAMPLE_IVL:  sample_ivl_reg  <= pwdata[INTERVAL_W-1:0];
                    REG_DISPLAY_IVL: display_ivl_reg <= pwdata[INTERVAL_W-1:0];
                    REG_EMA_WEIGHT:  weight_reg      <= pwdata[WEIGHT_W-1:0];
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        f_base_reg          <= f_base_next;
        diff_reg            <= diff_next;
        prod_hi_reg         <= prod_hi_next;
        prod_lo_reg         <= prod_lo_next;
        dvd_reg             <= dvd_next;
        rem_reg             <= rem_next;
        den_reg             <= den_next;
        div_neg_reg         <= div_neg_next;
        filtered_temp_reg   <= filtered_temp_next;
        display_temp_reg    <= display_temp_next;
        sample_taken_reg    <= sample_taken_next;
        display_updated_reg <= display_updated_next;
    end

    assign out_valid       = out_valid_reg;
    assign filtered_temp   = filtered_temp_reg;
    assign display_temp    = display_temp_reg;
    assign sample_taken    = sample_taken_reg;
    assign display_updated = display_updated_reg;

    // ---------------------------------------------------------------- assertions

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("accepted beat did not start processing");

    a_mul_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL && mul_cnt_reg == {MUL_CNT_W{1'b1}}) |=> (state_reg == ST_ACC))
        else $error("multiplier did not finish after all weight bits");

    a_window_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (window_count_reg == '0 && window_sum_reg == '0))
        else $error("window not cleared while dividing");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid_reg && out_stall) |=> (state_reg == ST_DONE))
        else $error("result overwrote a beat still waiting at the output");

endmodule

[tb/tb_top.sv]
// Self-checking bench for the EMA temperature filter with windowed average.
`timescale 1ns / 1ps

module tb_top;
    import ewa_pkg::*;

    localparam int SB          = 18;
    localparam int MAX_COUNT   = 255;
    localparam int CYCLE_LIMIT = 500_000;
    localparam int TAIL_CYCLES = 80;

    localparam logic [ADDR_W-1:0] SAMPLE_IVL_ADDR  = ADDR_W'(4 * REG_SAMPLE_IVL);
    localparam logic [ADDR_W-1:0] DISPLAY_IVL_ADDR = ADDR_W'(4 * REG_DISPLAY_IVL);
    localparam logic [ADDR_W-1:0] EMA_WEIGHT_ADDR  = ADDR_W'(4 * REG_EMA_WEIGHT);
    localparam logic [ADDR_W-1:0] UNMAPPED_ADDR    = ADDR_W'(4 * (REG_EMA_WEIGHT + 1));

    localparam logic signed [SB-1:0] TEMP_MIN = {1'b1, {(SB-1){1'b0}}};
    localparam logic signed [SB-1:0] TEMP_MAX = {1'b0, {(SB-1){1'b1}}};

    typedef struct {
        logic [TIME_W-1:0]    now;
        logic signed [SB-1:0] temp;
    } reading_t;

    typedef struct {
        logic signed [SB-1:0] filt;
        logic signed [SB-1:0] disp;
        logic                 taken;
        logic                 shown;
    } temp_report_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [TIME_W-1:0]     now_ms    = '0;
    logic signed [SB-1:0]  sample    = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic signed [SB-1:0]  filtered_temp;
    logic signed [SB-1:0]  display_temp;
    logic                  sample_taken;
    logic                  display_updated;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [ADDR_W-1:0]     paddr     = '0;
    logic [DATA_W-1:0]     pwdata    = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    ema_filter_with_windowed_average_top #(
        .SAMPLE_BITS (SB),
        .MAX_COUNT   (MAX_COUNT)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .now_ms          (now_ms),
        .sample          (sample),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .filtered_temp   (filtered_temp),
        .display_temp    (display_temp),
        .sample_taken    (sample_taken),
        .display_updated (display_updated),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #2 clk = ~clk;

    // Predictor state and its copy of the registers
    logic [INTERVAL_W-1:0] cfg_sample_ivl  = SAMPLE_IVL_RST;
    logic [INTERVAL_W-1:0] cfg_display_ivl = DISPLAY_IVL_RST;
    logic [WEIGHT_W-1:0]   cfg_weight      = EMA_WEIGHT_RST;
    logic [TIME_W-1:0]     seen_sample_at  = '0;
    logic [TIME_W-1:0]     seen_display_at = '0;
    logic signed [SB-1:0]  ema_now         = '0;
    logic                  ema_seeded      = 1'b0;
    longint                win_sum         = 0;
    int                    win_count       = 0;
    logic signed [SB-1:0]  shown_avg       = '0;

    reading_t     reading_queue[$];
    temp_report_t awaited_temps[$];

    int          readings_queued = 0;
    int          results_checked = 0;
    int          taken_beats     = 0;
    int          offered_beats   = 0;
    int          mismatches      = 0;
    int          cycle_count     = 0;
    int          idle_left       = 0;
    int          burst_left      = 1;
    int          stall_left      = 0;
    logic        stall_level     = 1'b0;
    logic [TIME_W-1:0] clk_ms    = '0;

    function automatic void advance_filter(input logic [TIME_W-1:0] now,
                                           input logic signed [SB-1:0] x);
        logic [TIME_W-1:0] since_sample;
        logic [TIME_W-1:0] since_display;
        longint            f;
        longint            prod;
        longint            q;
        temp_report_t      rep;
        since_sample  = now - seen_sample_at;
        since_display = now - seen_display_at;
        rep.taken = 1'b0;
        rep.shown = 1'b0;
        if (since_sample >= TIME_W'(cfg_sample_ivl)) begin
            if (!ema_seeded) begin
                ema_now    = x;
                ema_seeded = 1'b1;
            end
            f    = ema_now;
            prod = longint'(cfg_weight) * (longint'(x) - f);
            // arithmetic shift floors, as the update rule requires
            f       = f + (prod >>> 16);
            ema_now = f[SB-1:0];
            if (win_count < MAX_COUNT) begin
                win_sum   += f;
                win_count += 1;
            end
            seen_sample_at = now;
            rep.taken      = 1'b1;
        end
        if (since_display >= TIME_W'(cfg_display_ivl)) begin
            if (win_count > 0) begin
                q         = win_sum / longint'(win_count);
                shown_avg = q[SB-1:0];
                win_sum   = 0;
                win_count = 0;
                rep.shown = 1'b1;
            end
            seen_display_at = now;
        end
        rep.filt = ema_now;
        rep.disp = shown_avg;
        awaited_temps.push_back(rep);
    endfunction

    function automatic void check_field(input string what, input logic signed [31:0] want,
                                        input logic signed [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0d got %0d", $time, what, want, got);
        end
    endfunction

    // Driver: bursts of beats with random gaps
    always @(negedge clk) begin : feed
        logic     next_valid;
        reading_t beat;
        next_valid = in_valid;
        if (in_valid && taken_beats == offered_beats)
            next_valid = 1'b0;
        if (!next_valid) begin
            if (idle_left > 0)
                idle_left--;
            else if (reading_queue.size() > 0) begin
                beat = reading_queue.pop_front();
                now_ms <= beat.now;
                sample <= beat.temp;
                next_valid = 1'b1;
                offered_beats++;
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                    case ($urandom_range(0, 5))
                        0, 1:    idle_left = 0;
                        5:       idle_left = $urandom_range(20, 60);
                        default: idle_left = $urandom_range(1, 8);
                    endcase
                end
            end
        end
        in_valid <= next_valid;
    end

    // Receiver stall pattern: short stall runs, short and long clear runs
    always @(negedge clk) begin
        if (stall_left == 0) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    stall_level = 1'b0;
                    stall_left  = $urandom_range(1, 15);
                end
                9: begin
                    stall_level = 1'b0;
                    stall_left  = $urandom_range(40, 120);
                end
                default: begin
                    stall_level = 1'b1;
                    stall_left  = $urandom_range(1, 8);
                end
            endcase
        end else
            stall_left--;
        out_stall <= stall_level;
    end

    // Monitor: predict on each input beat, check each output beat
    always @(posedge clk) begin : observe
        temp_report_t want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                results_checked++;
                if (awaited_temps.size() == 0) begin
                    mismatches++;
                    $display("%0t: output beat with nothing expected", $time);
                end else begin
                    want = awaited_temps.pop_front();
                    check_field("filtered_temp", want.filt, filtered_temp);
                    check_field("display_temp", want.disp, display_temp);
                    check_field("sample_taken", want.taken, sample_taken);
                    check_field("display_updated", want.shown, display_updated);
                end
            end
            if (in_valid && !in_stall) begin
                advance_filter(now_ms, sample);
                taken_beats++;
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic queue_reading(input logic [TIME_W-1:0] now, input logic signed [SB-1:0] t);
        reading_t r;
        r.now  = now;
        r.temp = t;
        reading_queue.push_back(r);
        readings_queued++;
        clk_ms = now;
    endtask

    task automatic queue_random_run(input int count, input int max_step, input bit noisy);
        logic signed [SB-1:0] t;
        logic [TIME_W-1:0]    stamp;
        for (int i = 0; i < count; i++) begin
            if (noisy && $urandom_range(0, 19) == 0)
                stamp = $urandom;
            else
                stamp = clk_ms + TIME_W'($urandom_range(0, max_step));
            case ($urandom_range(0, 7))
                0:       t = TEMP_MIN;
                1:       t = TEMP_MAX;
                2:       t = SB'($urandom_range(0, 4095)) - SB'(2048);
                default: t = SB'($urandom);
            endcase
            queue_reading(stamp, t);
        end
    endtask

    // Wait until every queued beat has come back, then let the block settle
    task automatic drain();
        while (results_checked != readings_queued)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic apb_cycle(input logic wr, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = addr;
        pwdata  = wdata;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_reg(input logic [ADDR_W-1:0] addr, input logic [15:0] val);
        logic [DATA_W-1:0] rd;
        // upper bits are junk; only the low 16 should land
        apb_cycle(1'b1, addr, {16'($urandom), val}, rd);
        case (addr)
            SAMPLE_IVL_ADDR:  cfg_sample_ivl  = val;
            DISPLAY_IVL_ADDR: cfg_display_ivl = val;
            EMA_WEIGHT_ADDR:  cfg_weight      = val;
            default: ;
        endcase
        if (addr != UNMAPPED_ADDR) begin
            apb_cycle(1'b0, addr, '0, rd);
            if (rd[15:0] !== val) begin
                mismatches++;
                $display("%0t: register at %0d expected %0d got %0d", $time, addr, val, rd[15:0]);
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset settings (20 ms, 250 ms, 9830)
        queue_reading(32'd0, 18'sd0);
        queue_reading(32'd20, TEMP_MIN);         // seeds the filter
        queue_reading(32'd39, TEMP_MAX);         // interval not yet elapsed
        queue_reading(32'd40, TEMP_MAX);
        queue_reading(32'd250, 18'sd5);          // first window average
        queue_reading(32'd251, -18'sd1);
        queue_reading(32'd300, 18'sd0);          // sample only
        queue_reading(32'd600, 18'sd100);
        queue_reading(32'd700, 18'sd0);          // sample only
        queue_reading(32'hFFFF_FFFF, TEMP_MIN);
        queue_reading(32'h0000_0013, TEMP_MAX);  // wrap-around, exactly 20 ms
        queue_reading(32'h0000_0012, 18'sd7);    // time steps back: huge elapsed
        queue_reading(32'hAAAA_AAAA, 18'sh15555);
        queue_reading(32'h5555_5555, 18'sh2AAAA);
        drain();

        // Zero weight and zero intervals, plus a write to an unknown register
        set_reg(EMA_WEIGHT_ADDR, 16'd0);
        set_reg(SAMPLE_IVL_ADDR, 16'd0);
        set_reg(DISPLAY_IVL_ADDR, 16'd0);
        set_reg(UNMAPPED_ADDR, 16'hFFFF);
        queue_reading(clk_ms, TEMP_MAX);
        queue_reading(clk_ms, TEMP_MIN);
        queue_reading(clk_ms + 1, 18'sd1);
        queue_reading(clk_ms, -18'sd3);
        drain();

        set_reg(EMA_WEIGHT_ADDR, 16'hFFFF);
        set_reg(SAMPLE_IVL_ADDR, 16'hFFFF);
        set_reg(DISPLAY_IVL_ADDR, 16'hFFFF);
        queue_reading(clk_ms + 32'hFFFE, TEMP_MAX);
        queue_reading(clk_ms + 32'h1, TEMP_MAX); // exactly 65535 after the last sample
        queue_reading(clk_ms + 32'h1_0000, TEMP_MIN);
        drain();

        // Fill the window past its limit, then show it
        set_reg(SAMPLE_IVL_ADDR, 16'd0);
        set_reg(EMA_WEIGHT_ADDR, 16'($urandom_range(1, 65535)));
        queue_random_run(270, 2, 1'b0);
        queue_reading(clk_ms + 32'hFFFF, TEMP_MIN);
        drain();

        set_reg(EMA_WEIGHT_ADDR, 16'd0);
        set_reg(SAMPLE_IVL_ADDR, 16'd1);
        set_reg(DISPLAY_IVL_ADDR, 16'd3);
        queue_random_run(40, 4, 1'b1);
        drain();

        set_reg(SAMPLE_IVL_ADDR, 16'd5);
        set_reg(DISPLAY_IVL_ADDR, 16'd30);
        set_reg(EMA_WEIGHT_ADDR, 16'($urandom_range(1, 65535)));
        queue_random_run(60, 15, 1'b1);
        drain();

        set_reg(SAMPLE_IVL_ADDR, SAMPLE_IVL_RST);
        set_reg(DISPLAY_IVL_ADDR, DISPLAY_IVL_RST);
        set_reg(EMA_WEIGHT_ADDR, EMA_WEIGHT_RST);
        queue_random_run(60, 60, 1'b1);
        drain();

        set_reg(SAMPLE_IVL_ADDR, 16'hFFFF);
        set_reg(DISPLAY_IVL_ADDR, 16'hFFFF);
        set_reg(EMA_WEIGHT_ADDR, 16'd1);
        queue_random_run(30, 40000, 1'b1);

        while (results_checked != readings_queued)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0 && awaited_temps.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[sim.f]
hdl/ewa_pkg.sv
hdl/ema_filter_with_windowed_average_top.sv
tb/tb_top.sv
